@@ rtl/core/sll_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sll_pkg
// Shared constants for the static linked-list engine: operation and status
// codes, port field widths and default pool dimensions.
// ----------------------------------------------------------------------------
package sll_pkg;

    // Default pool dimensions.
    localparam int DEF_SLOTS      = 64;
    localparam int DEF_VALUE_BITS = 32;

    // Input field widths.
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 7;
    localparam int IN_W     = 48;

    // Output field widths.
    localparam int STATUS_W   = 3;
    localparam int NEW_SLOT_W = 6;
    localparam int FREE_W     = 7;
    localparam int OUT_W      = 88;

    // Operation codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTIN  = 3'd4;

endpackage : sll_pkg
`default_nettype wire

@@ rtl/core/sll_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sll_store
// Link and value memories of the slot pool. One read address serves both
// memories with a registered read; separate write ports for links and values.
// Slots at or above the fill mark were never taken and read their reset link
// (the next slot index), so the link memory needs no clearing pass.
// ----------------------------------------------------------------------------
module sll_store #(
    parameter int SLOTS      = sll_pkg::DEF_SLOTS,
    parameter int VALUE_BITS = sll_pkg::DEF_VALUE_BITS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          rd_en,
    input  wire [$clog2(SLOTS)-1:0]      rd_addr,
    output logic [$clog2(SLOTS+1)-1:0]   rd_link,
    output logic [VALUE_BITS-1:0]        rd_value,
    input  wire                          lwr_en,
    input  wire [$clog2(SLOTS)-1:0]      lwr_addr,
    input  wire [$clog2(SLOTS+1)-1:0]    lwr_data,
    input  wire                          vwr_en,
    input  wire [$clog2(SLOTS)-1:0]      vwr_addr,
    input  wire [VALUE_BITS-1:0]         vwr_data
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int LW   = $clog2(SLOTS + 1);

    logic [LW-1:0]         link_mem [SLOTS];
    logic [VALUE_BITS-1:0] value_mem [SLOTS];

    logic [LW-1:0]   link_q_reg;
    logic [IDXW-1:0] rd_addr_reg;
    logic            fresh_reg;
    logic            fresh_next;
    logic [LW-1:0]   mark_reg;
    logic [LW-1:0]   mark_next;

    // Memory ports: writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (lwr_en)
        begin
            link_mem[lwr_addr] <= lwr_data;
        end
        if (vwr_en)
        begin
            value_mem[vwr_addr] <= vwr_data;
        end
        if (rd_en)
        begin
            link_q_reg  <= link_mem[rd_addr];
            rd_value    <= value_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Fill mark: the lowest slot that has never held a value.
    always_comb
    begin
        mark_next  = mark_reg;
        fresh_next = fresh_reg;
        if (vwr_en && (LW'(vwr_addr) == mark_reg))
        begin
            mark_next = mark_reg + LW'(1);
        end
        if (rd_en)
        begin
            fresh_next = (LW'(rd_addr) >= mark_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            mark_reg  <= mark_next;
            fresh_reg <= fresh_next;
        end
    end

    // A never-used slot links to the slot after it; the last one to null.
    assign rd_link = fresh_reg ? (LW'(rd_addr_reg) + LW'(1)) : link_q_reg;

endmodule : sll_store
`default_nettype wire

@@ rtl/core/static_linked_list_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// static_linked_list_engine
// A pool of SLOTS slots kept as one data list plus a free list, with insert at
// head, delete by slot index and a list query.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ stream (action, value, slot) and each command
//   gives exactly one result transaction on the m_ stream (status, new slot,
//   free count, head and tail values, ascending flag, empty flag).
//   The engine works on one command at a time; s_tready is high while it is
//   idle. Slot state lives in a link memory and a value memory with a
//   registered read, and every list step costs one such read.
//   A rejected command goes straight to its result. An insert reads the free
//   head and then links the new slot at the list head; a delete of the head
//   reads that slot and then frees it; any other delete walks the list link
//   by link to the predecessor, bridges it over the slot and then frees the
//   slot, or ends with a not-in-list status at the tail; a query walks every
//   entry. The next command is taken in the cycle after the result is loaded.
//   The result waits in an output register; while the receiver stalls, the
//   next command is still accepted and worked on up to its own result.
//   Reset empties the list and frees all slots at once; no clearing pass is
//   needed and the first command is taken in the cycle after reset ends.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
    parameter int SLOTS      = sll_pkg::DEF_SLOTS,
    parameter int VALUE_BITS = sll_pkg::DEF_VALUE_BITS
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    // [1:0] action, [33:2] value, [40:34] slot, [47:41] zero
    input  wire  [sll_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    // [2:0] status, [8:3] new_slot, [15:9] free_count, [47:16] first_value,
    // [79:48] last_value, [80] ascending, [81] list_empty, [87:82] zero
    output logic [sll_pkg::OUT_W-1:0]  m_tdata
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int LW   = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_WR  = 3'd1;
    localparam logic [2:0] S_DEL_HD  = 3'd2;
    localparam logic [2:0] S_DEL_WK  = 3'd3;
    localparam logic [2:0] S_DEL_UL  = 3'd4;
    localparam logic [2:0] S_DEL_FR  = 3'd5;
    localparam logic [2:0] S_Q_WALK  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    // Input fields.
    logic [sll_pkg::ACTION_W-1:0] in_action;
    logic [sll_pkg::VALUE_W-1:0]  in_value;
    logic [sll_pkg::SLOT_W-1:0]   in_slot;
    logic [63:0]                  in_value_wide;
    logic                         in_slot_range;

    assign in_action     = s_tdata[1:0];
    assign in_value      = s_tdata[33:2];
    assign in_slot       = s_tdata[40:34];
    assign in_value_wide = 64'(in_value);
    assign in_slot_range = (32'(in_slot) >= 32'(SLOTS));

    // Control state.
    logic [2:0]      state_reg, state_next;
    logic [LW-1:0]   head_reg, head_next;
    logic [LW-1:0]   free_head_reg, free_head_next;
    logic [LW-1:0]   count_reg, count_next;
    logic            first_flag_reg, first_flag_next;
    logic            out_valid_reg, out_valid_next;

    // Per-command payload.
    logic [VALUE_BITS-1:0]        value_reg, value_next;
    logic [IDXW-1:0]              slot_reg, slot_next;
    logic [IDXW-1:0]              prev_reg, prev_next;
    logic [sll_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IDXW-1:0]              new_slot_reg, new_slot_next;
    logic signed [VALUE_BITS-1:0] first_val_reg, first_val_next;
    logic signed [VALUE_BITS-1:0] last_val_reg, last_val_next;
    logic                         asc_reg, asc_next;
    logic [sll_pkg::OUT_W-1:0]    out_data_reg, out_data_next;

    // Memory port signals.
    logic                    rd_en;
    logic [IDXW-1:0]         rd_addr;
    logic [LW-1:0]           rd_link;
    logic [VALUE_BITS-1:0]   rd_value;
    logic signed [VALUE_BITS-1:0] rd_value_s;
    logic                    lwr_en;
    logic [IDXW-1:0]         lwr_addr;
    logic [LW-1:0]           lwr_data;
    logic                    vwr_en;

    // Output formatting.
    logic        out_free;
    logic [63:0] first_ext;
    logic [63:0] last_ext;
    logic        list_empty;

    assign rd_value_s = rd_value;
    assign out_free   = !out_valid_reg || m_tready;
    assign first_ext  = 64'(first_val_reg);
    assign last_ext   = 64'(last_val_reg);
    assign list_empty = (count_reg == NIL);

    sll_store #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_link  (rd_link),
        .rd_value (rd_value),
        .lwr_en   (lwr_en),
        .lwr_addr (lwr_addr),
        .lwr_data (lwr_data),
        .vwr_en   (vwr_en),
        .vwr_addr (free_head_reg[IDXW-1:0]),
        .vwr_data (value_reg)
    );

    // Sequencer: command decode, list walks and read-modify-write of links.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        free_head_next  = free_head_reg;
        count_next      = count_reg;
        first_flag_next = first_flag_reg;
        out_valid_next  = out_valid_reg;
        value_next      = value_reg;
        slot_next       = slot_reg;
        prev_next       = prev_reg;
        status_next     = status_reg;
        new_slot_next   = new_slot_reg;
        first_val_next  = first_val_reg;
        last_val_next   = last_val_reg;
        asc_next        = asc_reg;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg[IDXW-1:0];
        lwr_en          = 1'b0;
        lwr_addr        = slot_reg;
        lwr_data        = free_head_reg;
        vwr_en          = 1'b0;
        s_tready        = (state_reg == S_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    value_next     = in_value_wide[VALUE_BITS-1:0];
                    slot_next      = IDXW'(in_slot);
                    status_next    = sll_pkg::ST_OK;
                    new_slot_next  = '0;
                    first_val_next = '0;
                    last_val_next  = '0;
                    asc_next       = 1'b0;
                    state_next     = S_DONE;
                    unique case (in_action)
                        sll_pkg::ACT_INSERT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sll_pkg::ST_FULL;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = free_head_reg[IDXW-1:0];
                                state_next = S_INS_WR;
                            end
                        end
                        sll_pkg::ACT_DELETE:
                        begin
                            if (in_slot_range)
                            begin
                                status_next = sll_pkg::ST_RANGE;
                            end
                            else if (head_reg == NIL)
                            begin
                                status_next = sll_pkg::ST_EMPTY;
                            end
                            else if (LW'(in_slot) == head_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IDXW'(in_slot);
                                state_next = S_DEL_HD;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg[IDXW-1:0];
                                prev_next  = head_reg[IDXW-1:0];
                                state_next = S_DEL_WK;
                            end
                        end
                        sll_pkg::ACT_QUERY:
                        begin
                            if (head_reg == NIL)
                            begin
                                status_next = sll_pkg::ST_EMPTY;
                                asc_next    = 1'b1;
                            end
                            else
                            begin
                                rd_en           = 1'b1;
                                rd_addr         = head_reg[IDXW-1:0];
                                first_flag_next = 1'b1;
                                state_next      = S_Q_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = sll_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // Pop the free head, store the value and link it at the list head.
            S_INS_WR:
            begin
                lwr_en         = 1'b1;
                lwr_addr       = free_head_reg[IDXW-1:0];
                lwr_data       = head_reg;
                vwr_en         = 1'b1;
                head_next      = free_head_reg;
                free_head_next = rd_link;
                count_next     = count_reg - LW'(1);
                new_slot_next  = free_head_reg[IDXW-1:0];
                state_next     = S_DONE;
            end

            // The slot is the head: the list now starts at its successor.
            S_DEL_HD:
            begin
                head_next      = rd_link;
                lwr_en         = 1'b1;
                lwr_addr       = slot_reg;
                lwr_data       = free_head_reg;
                free_head_next = LW'(slot_reg);
                count_next     = count_reg + LW'(1);
                state_next     = S_DONE;
            end

            // Walk one link per cycle looking for the predecessor.
            S_DEL_WK:
            begin
                if (rd_link == LW'(slot_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_reg;
                    state_next = S_DEL_UL;
                end
                else if (rd_link == NIL)
                begin
                    status_next = sll_pkg::ST_NOTIN;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rd_link[IDXW-1:0];
                    prev_next = rd_link[IDXW-1:0];
                end
            end

            // Bridge the predecessor over the deleted slot.
            S_DEL_UL:
            begin
                lwr_en     = 1'b1;
                lwr_addr   = prev_reg;
                lwr_data   = rd_link;
                state_next = S_DEL_FR;
            end

            // Push the deleted slot onto the free list.
            S_DEL_FR:
            begin
                lwr_en         = 1'b1;
                lwr_addr       = slot_reg;
                lwr_data       = free_head_reg;
                free_head_next = LW'(slot_reg);
                count_next     = count_reg + LW'(1);
                state_next     = S_DONE;
            end

            // Query walk: track head and tail values and the ordering.
            S_Q_WALK:
            begin
                first_flag_next = 1'b0;
                if (first_flag_reg)
                begin
                    first_val_next = rd_value_s;
                    asc_next       = 1'b1;
                end
                else if (rd_value_s < last_val_reg)
                begin
                    asc_next = 1'b0;
                end
                last_val_next = rd_value_s;
                if (rd_link == NIL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_link[IDXW-1:0];
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = {6'd0, list_empty, asc_reg, last_ext[31:0],
                                      first_ext[31:0],
                                      sll_pkg::FREE_W'(count_reg),
                                      sll_pkg::NEW_SLOT_W'(new_slot_reg),
                                      status_reg};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= NIL;
            free_head_reg  <= '0;
            count_reg      <= NIL;
            first_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            free_head_reg  <= free_head_next;
            count_reg      <= count_next;
            first_flag_reg <= first_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        slot_reg      <= slot_next;
        prev_reg      <= prev_next;
        status_reg    <= status_next;
        new_slot_reg  <= new_slot_next;
        first_val_reg <= first_val_next;
        last_val_reg  <= last_val_next;
        asc_reg       <= asc_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The free count never exceeds the pool size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NIL)
        else $error("free count above pool size");

    // The free list is empty exactly when no slot is free.
    a_free_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (free_head_reg == NIL))
        else $error("free list head disagrees with free count");

    // The data list is empty exactly when every slot is free.
    a_list_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) == (count_reg == NIL))
        else $error("list head disagrees with free count");

endmodule : static_linked_list_engine
`default_nettype wire
